FILE: rtl/core/ppr_pkg.sv
package ppr_pkg;

  localparam int unsigned RotW   = 16;
  localparam int unsigned TransW = 21;
  localparam int unsigned PntW   = 20;
  localparam int unsigned ProdW  = RotW + PntW;
  localparam int unsigned AccW   = 40;
  localparam int unsigned OutW   = 24;
  localparam int unsigned CfgW   = 63;

  localparam logic [1:0] LastRow = 2'd2;

  // identity rotation rows, Q1.14
  localparam logic [47:0] RotRow0Rst = 48'h0000_0000_4000;
  localparam logic [47:0] RotRow1Rst = 48'h0000_4000_0000;
  localparam logic [47:0] RotRow2Rst = 48'h4000_0000_0000;

  typedef enum logic [2:0] {
    IdxRotI0  = 3'd0,
    IdxRotI1  = 3'd1,
    IdxRotI2  = 3'd2,
    IdxTransI = 3'd3,
    IdxRotJ0  = 3'd4,
    IdxRotJ1  = 3'd5,
    IdxRotJ2  = 3'd6,
    IdxTransJ = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][47:0]   rot;
    logic [TransW*3-1:0] trans;
  } pose_t;

  // dot: R[r][c]*p[c]; crs: a2*p1, a1*p2, a0*p2, a2*p0, a1*p0, a0*p1
  typedef struct packed {
    logic [2:0][ProdW-1:0] dot;
    logic [5:0][ProdW-1:0] crs;
  } prod_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] row;
    logic       last;
  } meta_t;

  typedef struct packed {
    logic [1:0]           row;
    logic [OutW-1:0]      residual;
    logic [2:0][OutW-1:0] h1;
    logic [2:0][OutW-1:0] h2;
    logic                 row_last;
    logic                 batch_done;
  } res_t;

  // 2^-24 scale in, round half up to 2^-10, saturate to 24 signed bits
  function automatic logic [OutW-1:0] round_sat(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] t;
    logic signed [AccW-15:0] y;
    logic [OutW-1:0] r;
    t = x + AccW'(64'sd8192);
    y = t[AccW-1:14];
    if (y > (AccW-14)'(64'sd8388607)) begin
      r = 24'h7FFFFF;
    end else if (y < -(AccW-14)'(64'sd8388608)) begin
      r = 24'h800000;
    end else begin
      r = y[OutW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/ppr_cfg_regs.sv
module ppr_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [ppr_pkg::CfgW-1:0] cfg_data_i,
  output ppr_pkg::pose_t           pose_i_o,
  output ppr_pkg::pose_t           pose_j_o
);

  ppr_pkg::pose_t pose_i_q, pose_i_d;
  ppr_pkg::pose_t pose_j_q, pose_j_d;

  always_comb begin
    pose_i_d = pose_i_q;
    pose_j_d = pose_j_q;
    if (cfg_we_i) begin
      unique case (ppr_pkg::cfg_idx_e'(cfg_idx_i))
        ppr_pkg::IdxRotI0:  pose_i_d.rot[0] = cfg_data_i[47:0];
        ppr_pkg::IdxRotI1:  pose_i_d.rot[1] = cfg_data_i[47:0];
        ppr_pkg::IdxRotI2:  pose_i_d.rot[2] = cfg_data_i[47:0];
        ppr_pkg::IdxTransI: pose_i_d.trans  = cfg_data_i;
        ppr_pkg::IdxRotJ0:  pose_j_d.rot[0] = cfg_data_i[47:0];
        ppr_pkg::IdxRotJ1:  pose_j_d.rot[1] = cfg_data_i[47:0];
        ppr_pkg::IdxRotJ2:  pose_j_d.rot[2] = cfg_data_i[47:0];
        ppr_pkg::IdxTransJ: pose_j_d.trans  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_i_q.rot[0] <= ppr_pkg::RotRow0Rst;
      pose_i_q.rot[1] <= ppr_pkg::RotRow1Rst;
      pose_i_q.rot[2] <= ppr_pkg::RotRow2Rst;
      pose_i_q.trans  <= '0;
      pose_j_q.rot[0] <= ppr_pkg::RotRow0Rst;
      pose_j_q.rot[1] <= ppr_pkg::RotRow1Rst;
      pose_j_q.rot[2] <= ppr_pkg::RotRow2Rst;
      pose_j_q.trans  <= '0;
    end else begin
      pose_i_q <= pose_i_d;
      pose_j_q <= pose_j_d;
    end
  end

  assign pose_i_o = pose_i_q;
  assign pose_j_o = pose_j_q;

endmodule

FILE: rtl/core/ppr_prod.sv
module ppr_prod (
  input  logic                             clk_i,
  input  logic [2:0][47:0]                 rot_i,
  input  logic [1:0]                       row_i,
  input  logic [2:0][ppr_pkg::PntW-1:0]    pnt_i,
  output ppr_pkg::prod_t                   prod_o
);

  logic [47:0]                   row_sel;
  logic signed [ppr_pkg::RotW-1:0] a [3];
  logic signed [ppr_pkg::PntW-1:0] p [3];
  ppr_pkg::prod_t prod_d, prod_q;

  // one row of R against the point: three dot terms and six cross terms
  always_comb begin
    row_sel = rot_i[row_i];
    for (int c = 0; c < 3; c++) begin
      a[c] = $signed(row_sel[16*c +: 16]);
      p[c] = $signed(pnt_i[c]);
    end
    for (int c = 0; c < 3; c++) begin
      prod_d.dot[c] = ppr_pkg::ProdW'(a[c] * p[c]);
    end
    prod_d.crs[0] = ppr_pkg::ProdW'(a[2] * p[1]);
    prod_d.crs[1] = ppr_pkg::ProdW'(a[1] * p[2]);
    prod_d.crs[2] = ppr_pkg::ProdW'(a[0] * p[2]);
    prod_d.crs[3] = ppr_pkg::ProdW'(a[2] * p[0]);
    prod_d.crs[4] = ppr_pkg::ProdW'(a[1] * p[0]);
    prod_d.crs[5] = ppr_pkg::ProdW'(a[0] * p[1]);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/core/ppr_sum.sv
module ppr_sum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ppr_pkg::prod_t                 prod_i_i,
  input  ppr_pkg::prod_t                 prod_j_i,
  input  logic [ppr_pkg::TransW*3-1:0]   trans_i_i,
  input  logic [ppr_pkg::TransW*3-1:0]   trans_j_i,
  input  ppr_pkg::meta_t                 meta_i,
  output logic                           valid_o,
  output ppr_pkg::res_t                  res_o
);

  localparam int unsigned AccW = ppr_pkg::AccW;

  logic signed [ppr_pkg::TransW-1:0] ti, tj;
  logic signed [ppr_pkg::TransW:0]   tdiff;
  logic signed [AccW-1:0]            acc;
  logic signed [AccW-1:0]            h1s [3];
  logic signed [AccW-1:0]            h2s [3];
  ppr_pkg::res_t res_d, res_q;
  logic          valid_q;

  always_comb begin
    ti    = $signed(trans_i_i[ppr_pkg::TransW*meta_i.row +: ppr_pkg::TransW]);
    tj    = $signed(trans_j_i[ppr_pkg::TransW*meta_i.row +: ppr_pkg::TransW]);
    tdiff = (ppr_pkg::TransW+1)'(tj) - (ppr_pkg::TransW+1)'(ti);
    acc   = AccW'(tdiff) <<< 14;
    for (int c = 0; c < 3; c++) begin
      acc = acc + AccW'($signed(prod_j_i.dot[c])) - AccW'($signed(prod_i_i.dot[c]));
    end
    for (int c = 0; c < 3; c++) begin
      // h1 is the negated cross row of pose i, h2 the plain one of pose j
      h1s[c] = AccW'($signed(prod_i_i.crs[2*c+1])) - AccW'($signed(prod_i_i.crs[2*c]));
      h2s[c] = AccW'($signed(prod_j_i.crs[2*c])) - AccW'($signed(prod_j_i.crs[2*c+1]));
    end
    res_d.row        = meta_i.row;
    res_d.residual   = ppr_pkg::round_sat(acc);
    for (int c = 0; c < 3; c++) begin
      res_d.h1[c] = ppr_pkg::round_sat(h1s[c]);
      res_d.h2[c] = ppr_pkg::round_sat(h2s[c]);
    end
    res_d.row_last   = (meta_i.row == ppr_pkg::LastRow);
    res_d.batch_done = (meta_i.row == ppr_pkg::LastRow) && meta_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= meta_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/core/point_pair_residual_jacobian_core.sv
// point-to-point residual and rotation jacobian rows for one point pair
// under two rigid poses. a transaction is accepted on a clock edge with
// start high and busy low; it yields three results, rows x, y, z in that
// order, on consecutive cycles, each marked by res_valid_o for one
// cycle. the receiver cannot stall: every result must be taken the cycle
// it shows. busy is high while row 0 or row 1 of the pair held in the
// input register is still to be issued, so a new pair can be accepted
// while the last row of the previous one is still being issued; the
// single row datapath is reused for x, y, z. the datapath is two register
// stages after the input register: a product stage (nine 16x20 multiplies
// per pose for the selected row) and a sum, round-half-up and 24-bit
// saturate stage. configuration writes take effect on the next edge and
// must only be made while no pair is in flight (busy low and res_valid_o
// quiet until the last row of the last pair has been shown).
module point_pair_residual_jacobian_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [ppr_pkg::CfgW-1:0]     cfg_data_i,
  // point pair command
  input  logic                         start,
  output logic                         busy,
  input  logic signed [19:0]           pi_x_i,
  input  logic signed [19:0]           pi_y_i,
  input  logic signed [19:0]           pi_z_i,
  input  logic signed [19:0]           pj_x_i,
  input  logic signed [19:0]           pj_y_i,
  input  logic signed [19:0]           pj_z_i,
  input  logic                         pair_is_last_i,
  // row results
  output logic                         res_valid_o,
  output logic [1:0]                   axis_row_o,
  output logic signed [23:0]           residual_o,
  output logic signed [23:0]           h1_rot_a_o,
  output logic signed [23:0]           h1_rot_b_o,
  output logic signed [23:0]           h1_rot_c_o,
  output logic signed [23:0]           h2_rot_a_o,
  output logic signed [23:0]           h2_rot_b_o,
  output logic signed [23:0]           h2_rot_c_o,
  output logic                         row_is_last_o,
  output logic                         batch_done_o
);

  ppr_pkg::pose_t pose_i, pose_j;
  ppr_pkg::prod_t prod_i, prod_j;
  ppr_pkg::meta_t meta_in, meta_q;
  ppr_pkg::res_t  res;

  // input register: pair payload plus row sequencing
  logic [2:0][ppr_pkg::PntW-1:0] pi_q, pj_q;
  logic                          last_q;
  logic                          valid_q, valid_d;
  logic [1:0]                    row_q, row_d;
  logic                          accept;

  ppr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pose_i_o   (pose_i),
    .pose_j_o   (pose_j)
  );

  // free to take a new pair unless rows 0 or 1 are still to be issued
  assign busy   = valid_q && (row_q != ppr_pkg::LastRow);
  assign accept = start && !busy;

  always_comb begin
    valid_d = valid_q;
    row_d   = row_q;
    if (accept) begin
      valid_d = 1'b1;
      row_d   = 2'd0;
    end else if (valid_q) begin
      if (row_q == ppr_pkg::LastRow) begin
        valid_d = 1'b0;
      end else begin
        row_d = row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      row_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      row_q   <= row_d;
    end
  end

  // pair payload, loaded only on acceptance
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pi_q   <= {pi_z_i, pi_y_i, pi_x_i};
      pj_q   <= {pj_z_i, pj_y_i, pj_x_i};
      last_q <= pair_is_last_i;
    end
  end

  // product stage, one instance per pose
  ppr_prod u_prod_i (
    .clk_i  (clk_i),
    .rot_i  (pose_i.rot),
    .row_i  (row_q),
    .pnt_i  (pi_q),
    .prod_o (prod_i)
  );

  ppr_prod u_prod_j (
    .clk_i  (clk_i),
    .rot_i  (pose_j.rot),
    .row_i  (row_q),
    .pnt_i  (pj_q),
    .prod_o (prod_j)
  );

  // row tag travels alongside the products
  assign meta_in.valid = valid_q;
  assign meta_in.row   = row_q;
  assign meta_in.last  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else begin
      meta_q <= meta_in;
    end
  end

  // sum, round and saturate into the result register
  ppr_sum u_sum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .prod_i_i  (prod_i),
    .prod_j_i  (prod_j),
    .trans_i_i (pose_i.trans),
    .trans_j_i (pose_j.trans),
    .meta_i    (meta_q),
    .valid_o   (res_valid_o),
    .res_o     (res)
  );

  assign axis_row_o    = res.row;
  assign residual_o    = $signed(res.residual);
  assign h1_rot_a_o    = $signed(res.h1[0]);
  assign h1_rot_b_o    = $signed(res.h1[1]);
  assign h1_rot_c_o    = $signed(res.h1[2]);
  assign h2_rot_a_o    = $signed(res.h2[0]);
  assign h2_rot_b_o    = $signed(res.h2[1]);
  assign h2_rot_c_o    = $signed(res.h2[2]);
  assign row_is_last_o = res.row_last;
  assign batch_done_o  = res.batch_done;

endmodule

FILE: tb/row_result_checker.sv
module row_result_checker
  import ppr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic signed [19:0]  pi_x_i,
  input  logic signed [19:0]  pi_y_i,
  input  logic signed [19:0]  pi_z_i,
  input  logic signed [19:0]  pj_x_i,
  input  logic signed [19:0]  pj_y_i,
  input  logic signed [19:0]  pj_z_i,
  input  logic                pair_is_last_i,
  input  logic                res_valid_i,
  input  logic [1:0]          axis_row_i,
  input  logic signed [23:0]  residual_i,
  input  logic signed [23:0]  h1_rot_a_i,
  input  logic signed [23:0]  h1_rot_b_i,
  input  logic signed [23:0]  h1_rot_c_i,
  input  logic signed [23:0]  h2_rot_a_i,
  input  logic signed [23:0]  h2_rot_b_i,
  input  logic signed [23:0]  h2_rot_c_i,
  input  logic                row_is_last_i,
  input  logic                batch_done_i,
  output int                  mismatch_cnt_o,
  output int                  rows_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SatMax   = 64'sd8388607;
  localparam longint SatMin   = -64'sd8388608;
  localparam int     MaxShown = 10;

  // shadow copy of the pose registers
  logic [47:0]         rot_i_q [3];
  logic [47:0]         rot_j_q [3];
  logic [TransW*3-1:0] trans_i_q;
  logic [TransW*3-1:0] trans_j_q;

  res_t  expected_rows [$];
  int    errs;
  string field_names [10] = '{"axis_row", "residual", "h1_rot_a", "h1_rot_b", "h1_rot_c",
                              "h2_rot_a", "h2_rot_b", "h2_rot_c", "row_is_last",
                              "batch_done"};

  function automatic longint rot_entry(logic [47:0] row, int c);
    logic signed [15:0] e;
    e = row[16*c +: 16];
    return longint'(e);
  endfunction

  function automatic longint trans_comp(logic [TransW*3-1:0] t, int k);
    logic signed [20:0] e;
    e = t[21*k +: 21];
    return longint'(e);
  endfunction

  // 2^-24 in, half up to 2^-10, clamp to 24 signed bits
  function automatic logic [OutW-1:0] round_q10(longint x);
    longint y;
    y = (x + 64'sd8192) >>> 14;
    if (y > SatMax) return 24'h7FFFFF;
    if (y < SatMin) return 24'h800000;
    return 24'(y);
  endfunction

  function automatic res_t predict_row(int r, longint pi[3], longint pj[3], logic last);
    res_t   o;
    longint a [3];
    longint b [3];
    longint acc;
    for (int c = 0; c < 3; c++) begin
      a[c] = rot_entry(rot_i_q[r], c);
      b[c] = rot_entry(rot_j_q[r], c);
    end
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      acc += b[c] * pj[c] - a[c] * pi[c];
    end
    acc += (trans_comp(trans_j_q, r) - trans_comp(trans_i_q, r)) * 64'sd16384;
    o.row        = 2'(r);
    o.residual   = round_q10(acc);
    // rotation jacobian rows: -R*[p]x, negated again for pose i
    o.h1[0]      = round_q10(-(a[2] * pi[1] - a[1] * pi[2]));
    o.h1[1]      = round_q10(-(a[0] * pi[2] - a[2] * pi[0]));
    o.h1[2]      = round_q10(-(a[1] * pi[0] - a[0] * pi[1]));
    o.h2[0]      = round_q10(b[2] * pj[1] - b[1] * pj[2]);
    o.h2[1]      = round_q10(b[0] * pj[2] - b[2] * pj[0]);
    o.h2[2]      = round_q10(b[1] * pj[0] - b[0] * pj[1]);
    o.row_last   = (2'(r) == LastRow);
    o.batch_done = (2'(r) == LastRow) && last;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t        want;
    logic [23:0] want_f [10];
    logic [23:0] got_f [10];
    longint      pi_v [3];
    longint      pj_v [3];
    if (!rst_ni) begin
      rot_i_q[0] = RotRow0Rst;
      rot_i_q[1] = RotRow1Rst;
      rot_i_q[2] = RotRow2Rst;
      rot_j_q[0] = RotRow0Rst;
      rot_j_q[1] = RotRow1Rst;
      rot_j_q[2] = RotRow2Rst;
      trans_i_q  = '0;
      trans_j_q  = '0;
      expected_rows.delete();
      errs = 0;
    end else begin
      // compare the row on the ports against the oldest prediction
      if (res_valid_i) begin
        if (expected_rows.size() == 0) begin
          errs++;
          if (errs <= MaxShown) begin
            $display("unexpected row result: axis_row %0d residual %0d",
                     axis_row_i, residual_i);
          end
        end else begin
          want   = expected_rows.pop_front();
          want_f = '{24'(want.row), want.residual, want.h1[0], want.h1[1], want.h1[2],
                     want.h2[0], want.h2[1], want.h2[2], 24'(want.row_last),
                     24'(want.batch_done)};
          got_f  = '{24'(axis_row_i), residual_i, h1_rot_a_i, h1_rot_b_i, h1_rot_c_i,
                     h2_rot_a_i, h2_rot_b_i, h2_rot_c_i, 24'(row_is_last_i),
                     24'(batch_done_i)};
          for (int k = 0; k < 10; k++) begin
            if (want_f[k] !== got_f[k]) begin
              errs++;
              if (errs <= MaxShown) begin
                $display("row %0d %s mismatch: expected %0d, got %0d", want.row,
                         field_names[k], $signed(want_f[k]), $signed(got_f[k]));
              end
            end
          end
        end
      end

      // pose writes, bits above each register width are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          IdxRotI0:  rot_i_q[0] = cfg_data_i[47:0];
          IdxRotI1:  rot_i_q[1] = cfg_data_i[47:0];
          IdxRotI2:  rot_i_q[2] = cfg_data_i[47:0];
          IdxTransI: trans_i_q  = cfg_data_i[TransW*3-1:0];
          IdxRotJ0:  rot_j_q[0] = cfg_data_i[47:0];
          IdxRotJ1:  rot_j_q[1] = cfg_data_i[47:0];
          IdxRotJ2:  rot_j_q[2] = cfg_data_i[47:0];
          IdxTransJ: trans_j_q  = cfg_data_i[TransW*3-1:0];
          default: ;
        endcase
      end

      // accepted point pair: three rows x, y, z
      if (start_i && !busy_i) begin
        pi_v = '{longint'(pi_x_i), longint'(pi_y_i), longint'(pi_z_i)};
        pj_v = '{longint'(pj_x_i), longint'(pj_y_i), longint'(pj_z_i)};
        for (int r = 0; r < 3; r++) begin
          expected_rows.push_back(predict_row(r, pi_v, pj_v, pair_is_last_i));
        end
      end
    end
    mismatch_cnt_o <= errs;
    rows_pending_o <= expected_rows.size();
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ppr_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int TailCycles = 8;

  typedef enum int {
    PoseNearIdentity,
    PoseFull,
    PoseExtreme
  } pose_mode_e;

  // clock, reset and dut ports
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [2:0]          cfg_idx_i      = '0;
  logic [CfgW-1:0]     cfg_data_i     = '0;
  logic                start          = 1'b0;
  logic                busy;
  logic signed [19:0]  pi_x_i         = '0;
  logic signed [19:0]  pi_y_i         = '0;
  logic signed [19:0]  pi_z_i         = '0;
  logic signed [19:0]  pj_x_i         = '0;
  logic signed [19:0]  pj_y_i         = '0;
  logic signed [19:0]  pj_z_i         = '0;
  logic                pair_is_last_i = 1'b0;
  logic                res_valid_o;
  logic [1:0]          axis_row_o;
  logic signed [23:0]  residual_o;
  logic signed [23:0]  h1_rot_a_o;
  logic signed [23:0]  h1_rot_b_o;
  logic signed [23:0]  h1_rot_c_o;
  logic signed [23:0]  h2_rot_a_o;
  logic signed [23:0]  h2_rot_b_o;
  logic signed [23:0]  h2_rot_c_o;
  logic                row_is_last_o;
  logic                batch_done_o;

  int mismatch_cnt;
  int rows_pending;
  int cycle_cnt = 0;
  bit no_idle   = 1'b0;

  // pose about to be loaded
  logic [47:0]         ri_row [3];
  logic [47:0]         rj_row [3];
  logic [TransW*3-1:0] ti_reg;
  logic [TransW*3-1:0] tj_reg;

  always #10 clk_i = ~clk_i;

  point_pair_residual_jacobian_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .pi_x_i         (pi_x_i),
    .pi_y_i         (pi_y_i),
    .pi_z_i         (pi_z_i),
    .pj_x_i         (pj_x_i),
    .pj_y_i         (pj_y_i),
    .pj_z_i         (pj_z_i),
    .pair_is_last_i (pair_is_last_i),
    .res_valid_o    (res_valid_o),
    .axis_row_o     (axis_row_o),
    .residual_o     (residual_o),
    .h1_rot_a_o     (h1_rot_a_o),
    .h1_rot_b_o     (h1_rot_b_o),
    .h1_rot_c_o     (h1_rot_c_o),
    .h2_rot_a_o     (h2_rot_a_o),
    .h2_rot_b_o     (h2_rot_b_o),
    .h2_rot_c_o     (h2_rot_c_o),
    .row_is_last_o  (row_is_last_o),
    .batch_done_o   (batch_done_o)
  );

  // predicts every row and compares it, we only read back the counts
  row_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start),
    .busy_i         (busy),
    .pi_x_i         (pi_x_i),
    .pi_y_i         (pi_y_i),
    .pi_z_i         (pi_z_i),
    .pj_x_i         (pj_x_i),
    .pj_y_i         (pj_y_i),
    .pj_z_i         (pj_z_i),
    .pair_is_last_i (pair_is_last_i),
    .res_valid_i    (res_valid_o),
    .axis_row_i     (axis_row_o),
    .residual_i     (residual_o),
    .h1_rot_a_i     (h1_rot_a_o),
    .h1_rot_b_i     (h1_rot_b_o),
    .h1_rot_c_i     (h1_rot_c_o),
    .h2_rot_a_i     (h2_rot_a_o),
    .h2_rot_b_i     (h2_rot_b_o),
    .h2_rot_c_i     (h2_rot_c_o),
    .row_is_last_i  (row_is_last_o),
    .batch_done_i   (batch_done_o),
    .mismatch_cnt_o (mismatch_cnt),
    .rows_pending_o (rows_pending)
  );

  // watchdog against a hung handshake or lost rows
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] pack_row(logic [15:0] c0, logic [15:0] c1,
                                           logic [15:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [TransW*3-1:0] pack_trans(logic [20:0] x, logic [20:0] y,
                                                     logic [20:0] z);
    return {z, y, x};
  endfunction

  // rotation entry for a random pose, diagonal ones sit near 1.0 in near-identity mode
  function automatic logic [15:0] rot_pick(pose_mode_e m, bit diag);
    case (m)
      PoseNearIdentity: begin
        if (diag) return 16'(16384 + int'($urandom_range(0, 1024)) - 512);
        return 16'(int'($urandom_range(0, 4096)) - 2048);
      end
      PoseExtreme: begin
        case ($urandom_range(0, 5))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'h4000;
          4:       return 16'hC000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [20:0] trans_pick(pose_mode_e m);
    case (m)
      PoseNearIdentity: return 21'(int'($urandom_range(0, 40960)) - 20480);
      PoseExtreme: begin
        case ($urandom_range(0, 3))
          0:       return 21'h100000;
          1:       return 21'h0FFFFF;
          2:       return 21'h000000;
          default: return 21'h1FFFFF;
        endcase
      end
      default: return 21'($urandom);
    endcase
  endfunction

  // mostly uniform, one in eight an extreme or a value near zero
  function automatic logic [19:0] rand_coord();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0:       return 20'h80000;
        1:       return 20'h7FFFF;
        2:       return 20'h00000;
        3:       return 20'hFFFFF;
        default: return 20'h00001;
      endcase
    end
    return 20'($urandom);
  endfunction

  task automatic randomize_pose(pose_mode_e m);
    for (int r = 0; r < 3; r++) begin
      ri_row[r] = pack_row(rot_pick(m, r == 0), rot_pick(m, r == 1), rot_pick(m, r == 2));
      rj_row[r] = pack_row(rot_pick(m, r == 0), rot_pick(m, r == 1), rot_pick(m, r == 2));
    end
    ti_reg = pack_trans(trans_pick(m), trans_pick(m), trans_pick(m));
    tj_reg = pack_trans(trans_pick(m), trans_pick(m), trans_pick(m));
  endtask

  task automatic uniform_pose(logic [15:0] ri_e, logic [15:0] rj_e, logic [20:0] ti_e,
                              logic [20:0] tj_e);
    for (int r = 0; r < 3; r++) begin
      ri_row[r] = pack_row(ri_e, ri_e, ri_e);
      rj_row[r] = pack_row(rj_e, rj_e, rj_e);
    end
    ti_reg = pack_trans(ti_e, ti_e, ti_e);
    tj_reg = pack_trans(tj_e, tj_e, tj_e);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  // load all eight registers, rotation rows carry random junk above bit 47
  task automatic commit_pose();
    write_reg(IdxRotI0, {15'($urandom), ri_row[0]});
    write_reg(IdxRotI1, {15'($urandom), ri_row[1]});
    write_reg(IdxRotI2, {15'($urandom), ri_row[2]});
    write_reg(IdxTransI, ti_reg);
    write_reg(IdxRotJ0, {15'($urandom), rj_row[0]});
    write_reg(IdxRotJ1, {15'($urandom), rj_row[1]});
    write_reg(IdxRotJ2, {15'($urandom), rj_row[2]});
    write_reg(IdxTransJ, tj_reg);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random gap before a command: mostly none or short, sometimes long
  task automatic idle_gap();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 95) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 45);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // one point pair transaction, returns on the accepting edge
  task automatic send_pair(logic [19:0] ax, logic [19:0] ay, logic [19:0] az,
                           logic [19:0] bx, logic [19:0] by, logic [19:0] bz, logic last);
    idle_gap();
    @(negedge clk_i);
    pi_x_i         <= ax;
    pi_y_i         <= ay;
    pi_z_i         <= az;
    pj_x_i         <= bx;
    pj_y_i         <= by;
    pj_z_i         <= bz;
    pair_is_last_i <= last;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // stop issuing and let every predicted row come out, then a short pause
  task automatic drain_rows();
    @(negedge clk_i);
    start <= 1'b0;
    do @(negedge clk_i); while (rows_pending != 0);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  initial begin
    pose_mode_e plan [6];
    plan = '{PoseNearIdentity, PoseFull, PoseNearIdentity, PoseExtreme, PoseFull,
             PoseExtreme};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset pose: identity rotations, zero translations
    send_pair(20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h00000, 1'b0);
    send_pair(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b0);
    send_pair(20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000, 1'b1);
    send_pair(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 20'h80000, 1'b0);
    send_pair(20'h00001, 20'hFFFFF, 20'h7FFFF, 20'h80000, 20'h00000, 20'hFFFFF, 1'b0);
    drain_rows();

    // residual pushed close to the positive clamp
    uniform_pose(16'h7FFF, 16'h8000, 21'h100000, 21'h0FFFFF);
    commit_pose();
    send_pair(20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000, 1'b0);
    send_pair(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b1);
    drain_rows();

    // negative residual, mostly from the translation difference
    uniform_pose(16'h8000, 16'h7FFF, 21'h0FFFFF, 21'h100000);
    commit_pose();
    send_pair(20'h80000, 20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b0);
    send_pair(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 20'h80000, 1'b1);
    drain_rows();

    // unit rotation entries against multiples of half an lsb: rounding ties both ways
    ri_row[0] = pack_row(16'h0001, 16'hFFFF, 16'h0001);
    ri_row[1] = pack_row(16'hFFFF, 16'h0001, 16'h0001);
    ri_row[2] = pack_row(16'h0001, 16'h0001, 16'hFFFF);
    rj_row[0] = pack_row(16'hFFFF, 16'h0001, 16'h0001);
    rj_row[1] = pack_row(16'h0001, 16'h0001, 16'hFFFF);
    rj_row[2] = pack_row(16'h0001, 16'hFFFF, 16'h0001);
    ti_reg    = pack_trans(21'h000001, 21'h1FFFFF, 21'h000003);
    tj_reg    = pack_trans(21'h1FFFFF, 21'h000001, 21'h000000);
    commit_pose();
    send_pair(20'h02000, 20'hFE000, 20'h06000, 20'h01FFF, 20'hFDFFF, 20'h02000, 1'b0);
    send_pair(20'hFA000, 20'h02001, 20'hFE001, 20'hFE000, 20'h06000, 20'h00001, 1'b0);
    send_pair(20'h02000, 20'h00000, 20'h00000, 20'h00000, 20'hFE000, 20'h00000, 1'b1);
    drain_rows();

    // random poses, two phases run back to back with no gaps
    for (int p = 0; p < 6; p++) begin
      randomize_pose(plan[p]);
      commit_pose();
      no_idle = (p == 2) || (p == 5);
      repeat (50) begin
        send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), $urandom_range(0, 7) == 0);
      end
      drain_rows();
    end

    if (mismatch_cnt == 0 && rows_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
